/* rtl/core/csrms_pkg.sv */
// csrms_pkg: shared widths, constants and types for the column sum / RMS block.
// Used by csrms_front, csrms_queue, csrms_back and column_sum_or_rms.
package csrms_pkg;

    localparam int C_SAMPLE_W  = 16;
    localparam int C_SUM_W     = 28;
    localparam int C_SQ_W      = 43;
    localparam int C_CNT_W     = 13;
    localparam int C_COL_W     = 12;
    localparam int C_POWER_W   = 28;
    localparam int C_OUT_W     = C_COL_W + C_POWER_W;

    localparam int C_MAX_ROWS  = 4096;
    localparam int C_MAX_COLS  = 4096;

    // 8 fraction bits on the root means 16 fraction bits under the root
    localparam int C_FRAC2_W   = 16;
    localparam int C_SQ_SPLIT  = 22;
    localparam int C_MAG_W     = C_SUM_W;
    localparam int C_MAGSQ_W   = 2 * C_MAG_W;
    localparam int C_DEN_W     = 2 * C_CNT_W;
    localparam int C_PLO_W     = C_CNT_W + C_SQ_SPLIT;
    localparam int C_PHI_W     = C_CNT_W + C_SQ_W - C_SQ_SPLIT;
    localparam int C_NSQ_W     = C_CNT_W + C_SQ_W;
    localparam int C_NUM_W     = C_NSQ_W + C_FRAC2_W;
    localparam int C_X_W       = 48;
    localparam int C_ROOT_W    = C_X_W / 2;
    localparam int C_SREM_W    = C_ROOT_W + 4;
    localparam int C_STEP_W    = 7;

    typedef struct packed {
        logic [C_COL_W-1:0]        col;
        logic                      mode;
        logic signed [C_SUM_W-1:0] sum;
        logic [C_SQ_W-1:0]         sumsq;
        logic [C_CNT_W-1:0]        cnt;
    } t_col_entry;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

endpackage

/* rtl/core/csrms_front.sv */
// csrms_front: takes sample beats, accumulates sum, sum of squares and count,
// and pushes one column record at the end of each column. Uses csrms_pkg.
module csrms_front import csrms_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    input  logic                         i_valid,
    input  logic signed [C_SAMPLE_W-1:0] i_sample,
    input  logic                         i_last,
    input  t_q_status                    i_q_status,
    output logic                         o_ready,
    output logic                         o_push,
    output t_col_entry                   o_entry
);

    logic                        r_mode;
    logic signed [C_SUM_W-1:0]   r_sum;
    logic [C_SQ_W-1:0]           r_sumsq;
    logic [C_CNT_W-1:0]          r_cnt;
    logic [C_COL_W-1:0]          r_col;

    logic signed [2*C_SAMPLE_W-1:0] w_sq;
    logic                           w_take;
    logic                           w_acc;
    logic signed [C_SUM_W-1:0]      n_sum;
    logic [C_SQ_W-1:0]              n_sumsq;
    logic [C_CNT_W-1:0]             n_cnt;
    logic [C_COL_W-1:0]             n_col;

    assign o_ready = !i_q_status.full;
    assign w_take  = i_valid && o_ready;
    assign w_acc   = (32'(r_cnt) < C_MAX_ROWS);
    assign w_sq    = i_sample * i_sample;

    // past the row limit samples are dropped, the flagged one too
    assign n_sum   = w_acc ? r_sum + C_SUM_W'(i_sample) : r_sum;
    assign n_sumsq = w_acc ? r_sumsq + C_SQ_W'($unsigned(w_sq)) : r_sumsq;
    assign n_cnt   = w_acc ? r_cnt + C_CNT_W'(1) : r_cnt;
    assign n_col   = (32'(r_col) + 1 >= C_MAX_COLS) ? '0 : r_col + C_COL_W'(1);

    assign o_push        = w_take && i_last;
    assign o_entry.col   = r_col;
    assign o_entry.mode  = r_mode;
    assign o_entry.sum   = n_sum;
    assign o_entry.sumsq = n_sumsq;
    assign o_entry.cnt   = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_cnt   <= '0;
            r_col   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (w_take) begin
                if (i_last) begin
                    r_sum   <= '0;
                    r_sumsq <= '0;
                    r_cnt   <= '0;
                    r_col   <= n_col;
                end else begin
                    r_sum   <= n_sum;
                    r_sumsq <= n_sumsq;
                    r_cnt   <= n_cnt;
                end
            end
        end
    end

endmodule

/* rtl/core/csrms_queue.sv */
// csrms_queue: two-entry queue of finished column records between front and back.
// Uses csrms_pkg.
module csrms_queue import csrms_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_col_entry i_entry,
    input  logic       i_pop,
    output t_q_status  o_status,
    output t_col_entry o_head
);

    t_col_entry r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_fill;

    assign o_status.full      = r_fill[1];
    assign o_status.not_empty = (r_fill != 2'd0);
    assign o_head             = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

/* rtl/core/csrms_back.sv */
// csrms_back: turns a column record into the result beat: the sum directly, or
// the RMS through multiply, restoring divide and digit-by-digit square root.
// Uses csrms_pkg.
module csrms_back import csrms_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_q_status          i_q_status,
    input  t_col_entry         i_head,
    output logic               o_pop,
    output logic               o_tvalid,
    input  logic               i_tready,
    output logic [C_OUT_W-1:0] o_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_SUB,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } t_state;

    t_state                    r_state;
    logic                      r_out_valid;
    logic [C_OUT_W-1:0]        r_out_data;
    logic [C_COL_W-1:0]        r_col;
    logic signed [C_SUM_W-1:0] r_sum;
    logic [C_SQ_W-1:0]         r_sumsq;
    logic [C_CNT_W-1:0]        r_cnt;
    logic [C_MAGSQ_W-1:0]      r_sq;
    logic [C_PLO_W-1:0]        r_plo;
    logic [C_PHI_W-1:0]        r_phi;
    logic [C_DEN_W-1:0]        r_den;
    logic [C_NSQ_W-1:0]        r_nsq;
    logic [C_NUM_W-1:0]        r_num;
    logic [C_DEN_W-1:0]        r_rem;
    logic [C_X_W-1:0]          r_quo;
    logic [C_SREM_W-1:0]       r_srem;
    logic [C_ROOT_W-1:0]       r_root;
    logic [C_STEP_W-1:0]       r_step;
    logic [C_POWER_W-1:0]      r_res;

    logic [C_MAG_W-1:0]        w_mag;
    logic [C_DEN_W:0]          w_div_rem;
    logic                      w_div_ge;
    logic [C_DEN_W:0]          w_div_sub;
    logic [C_SREM_W-1:0]       w_sq_rem;
    logic [C_SREM_W-1:0]       w_trial;
    logic                      w_sq_ge;
    logic [C_ROOT_W-1:0]       n_root;

    assign w_mag     = r_sum[C_SUM_W-1] ? C_MAG_W'(-r_sum) : C_MAG_W'(r_sum);

    // one quotient bit per cycle
    assign w_div_rem = {r_rem, r_num[C_NUM_W-1]};
    assign w_div_ge  = (w_div_rem >= (C_DEN_W+1)'(r_den));
    assign w_div_sub = w_div_rem - (C_DEN_W+1)'(r_den);

    // one root bit per cycle, two radicand bits brought down
    assign w_sq_rem  = {r_srem[C_SREM_W-3:0], r_quo[C_X_W-1 -: 2]};
    assign w_trial   = {2'b00, r_root, 2'b01};
    assign w_sq_ge   = (w_sq_rem >= w_trial);
    assign n_root    = {r_root[C_ROOT_W-2:0], w_sq_ge};

    assign o_pop    = (r_state == ST_IDLE) && i_q_status.not_empty;
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // ST_OUT reloads the output register itself
            if (r_out_valid && i_tready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_status.not_empty) begin
                        r_col   <= i_head.col;
                        r_sum   <= i_head.sum;
                        r_sumsq <= i_head.sumsq;
                        r_cnt   <= i_head.cnt;
                        r_res   <= C_POWER_W'(i_head.sum);
                        r_state <= i_head.mode ? ST_MUL : ST_OUT;
                    end
                end
                ST_MUL: begin
                    r_sq  <= w_mag * w_mag;
                    r_plo <= r_cnt * r_sumsq[C_SQ_SPLIT-1:0];
                    r_phi <= r_cnt * r_sumsq[C_SQ_W-1:C_SQ_SPLIT];
                    r_den <= r_cnt * r_cnt;
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_nsq   <= (C_NSQ_W'(r_phi) << C_SQ_SPLIT) + C_NSQ_W'(r_plo);
                    r_state <= ST_SUB;
                end
                ST_SUB: begin
                    // non-positive variance, and a zero count, give zero
                    if (C_MAGSQ_W'(r_nsq) <= r_sq) begin
                        r_res   <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_num   <= {r_nsq - C_NSQ_W'(r_sq), {C_FRAC2_W{1'b0}}};
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_step  <= C_STEP_W'(C_NUM_W - 1);
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_num <= r_num << 1;
                    r_quo <= {r_quo[C_X_W-2:0], w_div_ge};
                    r_rem <= w_div_ge ? w_div_sub[C_DEN_W-1:0] : w_div_rem[C_DEN_W-1:0];
                    if (r_step == '0) begin
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_step  <= C_STEP_W'(C_ROOT_W - 1);
                        r_state <= ST_SQRT;
                    end else begin
                        r_step <= r_step - C_STEP_W'(1);
                    end
                end
                ST_SQRT: begin
                    r_quo  <= r_quo << 2;
                    r_root <= n_root;
                    r_srem <= w_sq_ge ? w_sq_rem - w_trial : w_sq_rem;
                    if (r_step == '0) begin
                        r_res   <= C_POWER_W'(n_root);
                        r_state <= ST_OUT;
                    end else begin
                        r_step <= r_step - C_STEP_W'(1);
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || i_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {r_res, r_col};
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/column_sum_or_rms.sv */
// column_sum_or_rms: top level of the per-column sum / RMS block.
// Instantiates csrms_front, csrms_queue and csrms_back; uses csrms_pkg.
//
//  channel   dir  handshake                    payload
//  --------  ---  ---------------------------  -----------------------------------
//  s_axis    in   i_s_axis_tvalid/o_..._tready  tdata[15:0] sample, tlast end of column
//  m_axis    out  o_m_axis_tvalid/i_..._tready  tdata[11:0] column index, [39:12] power
//  cfg       in   i_cfg_we                      i_cfg_wdata: rms_mode
//
// One sample beat is taken per cycle unless the queue is full; the front accumulates it.
// A column end pushes a record into a two-entry queue; the back drains it.
// Sum mode: a pop moves the back to its output state, which loads the result beat.
// RMS mode: the back multiplies, adds and subtracts, then runs the 72-step restoring
// divider and the 24-step square root, both one bit per cycle, before its output
// state; a non-positive variance goes to the output state with a zero result.
// The back pops a new column only in idle. A stalled result beat holds the back in
// its output state. The input stalls only while the queue holds two waiting columns.
// Reset is synchronous, active low; it clears accumulators, counters and mode.
module column_sum_or_rms import csrms_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [C_SAMPLE_W-1:0] i_s_axis_tdata,   // [15:0] sample
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [C_OUT_W-1:0]    o_m_axis_tdata    // [11:0] column_index, [39:12] power
);

    t_q_status  w_q_status;
    t_col_entry w_push_entry;
    t_col_entry w_head;
    logic       w_push;
    logic       w_pop;

    csrms_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .i_sample    ($signed(i_s_axis_tdata)),
        .i_last      (i_s_axis_tlast),
        .i_q_status  (w_q_status),
        .o_ready     (o_s_axis_tready),
        .o_push      (w_push),
        .o_entry     (w_push_entry)
    );

    csrms_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_status (w_q_status),
        .o_head   (w_head)
    );

    csrms_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_tvalid   (o_m_axis_tvalid),
        .i_tready   (i_m_axis_tready),
        .o_tdata    (o_m_axis_tdata)
    );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// testbench: self-checking bench for column_sum_or_rms (sum and RMS column modes).
// Depends on csrms_pkg and the column_sum_or_rms RTL; needs no files or arguments.

module testbench;
    import csrms_pkg::*;

    // Watchdog: cycles with no beat accepted on either side. RMS columns hold the back
    // through divide and square root steps and two can be queued, so this is generous.
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 12;    // wait before a mode write once results drain
    localparam int TAIL_CYCLES   = 300;   // catches stray results after the drain
    localparam int FLAT_LEN      = 64;
    localparam int RANDOM_BEATS  = 1670;
    localparam int DIR_ROWS      = 23;

    typedef enum logic { MODE_SUM = 1'b0, MODE_RMS = 1'b1 } t_power_mode;

    typedef enum logic [1:0] { ROW_BEAT, ROW_TO_SUM, ROW_TO_RMS } t_row_kind;

    typedef enum logic [2:0] {
        STY_WIDE, STY_EXTREME, STY_NARROW, STY_ALL_LOW, STY_ALL_HIGH, STY_SWING
    } t_col_style;

    typedef struct packed {
        logic [C_COL_W-1:0]          col;
        logic signed [C_POWER_W-1:0] power;
    } t_col_result;

    typedef struct packed {
        t_row_kind                   kind;
        logic [C_SAMPLE_W-1:0]       sample;
        logic                        is_last;
        logic                        typed;     // 1: expected result given in the row
        logic [C_COL_W-1:0]          col;
        logic signed [C_POWER_W-1:0] power;
    } t_dir_row;

    // ---------------------------------------------------------------------
    // DUT hookup. All inputs hold known values from time zero.
    // ---------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_wdata = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [C_SAMPLE_W-1:0] s_tdata   = '0;   // [15:0] sample
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [C_OUT_W-1:0]    m_tdata;          // [11:0] column_index, [39:12] power

    column_sum_or_rms i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------------
    // Column predictor state: mirrors the accumulators, the column counter
    // and the mode register of the block.
    // ---------------------------------------------------------------------
    logic signed [C_SUM_W-1:0] acc_sum = '0;
    logic [C_SQ_W-1:0]         acc_sq  = '0;
    logic [C_CNT_W-1:0]        acc_cnt = '0;
    logic [C_COL_W-1:0]        col_ctr = '0;
    t_power_mode               cur_mode = MODE_SUM;

    t_col_result column_results_due[$];   // oldest column first

    bit steady_flow = 1'b0;               // 1: neither side idles
    int sink_hold   = 0;
    int idle_cycles = 0;
    int mismatches  = 0;
    int results_seen = 0;
    int beats_sent  = 0;
    int sum_cols    = 0;
    int rms_cols    = 0;

    // floor(256 * sqrt((n*S2 - S^2) / n^2)), negative variance and n == 0 give 0.
    // Fraction is carried as 16 bits under the root; root found bit by bit.
    function automatic logic signed [C_POWER_W-1:0] rms_fixed8(
        input logic signed [C_SUM_W-1:0] col_sum,
        input logic [C_SQ_W-1:0]         col_sumsq,
        input logic [C_CNT_W-1:0]        col_cnt
    );
        longint          s;
        longint unsigned n, mag2, nsq, den, q, r, x, root, trial;
        int              b;
        if (col_cnt == 0) return '0;
        s    = col_sum;
        n    = col_cnt;
        mag2 = s * s;
        nsq  = n * col_sumsq;
        if (nsq <= mag2) return '0;
        den  = n * n;
        q    = (nsq - mag2) / den;
        r    = (nsq - mag2) % den;
        x    = (q << C_FRAC2_W) + ((r << C_FRAC2_W) / den);
        root = 0;
        for (b = 23; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) root = trial;
        end
        return C_POWER_W'(root);
    endfunction

    // Update on an accepted input beat; a column end queues its result.
    task automatic track_accepted_beat(input logic [C_SAMPLE_W-1:0] smp,
                                       input logic is_last, input logic typed,
                                       input t_col_result typed_res);
        longint      v;
        t_col_result res;
        v = longint'($signed(smp));
        beats_sent++;
        // past MAX_ROWS samples are dropped, the flagged one too
        if (int'(acc_cnt) < C_MAX_ROWS) begin
            acc_sum = acc_sum + C_SUM_W'(v);
            acc_sq  = acc_sq + C_SQ_W'(v * v);
            acc_cnt = acc_cnt + 1'b1;
        end
        if (is_last) begin
            res.col   = col_ctr;
            res.power = (cur_mode == MODE_RMS) ? rms_fixed8(acc_sum, acc_sq, acc_cnt)
                                               : acc_sum;
            column_results_due = {column_results_due, (typed ? typed_res : res)};
            if (cur_mode == MODE_RMS) rms_cols++;
            else sum_cols++;
            // 12-bit counter wraps at MAX_COLS
            col_ctr = col_ctr + 1'b1;
            acc_sum = '0;
            acc_sq  = '0;
            acc_cnt = '0;
        end
    endtask

    // Drive one beat after a random gap and wait for it to be taken. Valid
    // stays up on return so a back-to-back beat needs no second assignment.
    task automatic push_beat(input logic [C_SAMPLE_W-1:0] smp, input logic is_last,
                             input logic typed, input t_col_result typed_res);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= is_last;
        do @(posedge clk); while (!s_tready);
        track_accepted_beat(smp, is_last, typed, typed_res);
    endtask

    task automatic wait_all_results();
        while (column_results_due.size() != 0) @(posedge clk);
    endtask

    // Mode changes only with the block idle: input parked, results drained.
    task automatic write_mode(input t_power_mode m);
        s_tvalid <= 1'b0;
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_mode = m;
    endtask

    function automatic logic [C_SAMPLE_W-1:0] pick_sample(input t_col_style sty, input int idx,
                                                        input logic [C_SAMPLE_W-1:0] base);
        case (sty)
            STY_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            STY_NARROW:   return base + C_SAMPLE_W'($urandom_range(0, 15)) - 16'd8;
            STY_ALL_LOW:  return 16'h8000;
            STY_ALL_HIGH: return 16'h7FFF;
            STY_SWING:    return (idx % 2 == 0) ? 16'h7FFF : 16'h8000;
            default:      return C_SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_column(input int len, input t_col_style sty);
        logic [C_SAMPLE_W-1:0] base;
        int                    i;
        base = C_SAMPLE_W'($urandom_range(0, 65535));
        for (i = 0; i < len; i++)
            push_beat(pick_sample(sty, i, base), i == len - 1, 1'b0, '0);
    endtask

    // ---------------------------------------------------------------------
    // Directed rows. Sum mode is the reset value, so the first columns also
    // check it. Typed results are the obvious ones; the rest go through the
    // predictor.
    // ---------------------------------------------------------------------
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_BEAT,   16'h7FFF, 1'b1, 1'b1, 12'd0,  28'sd32767},   // max sample
        '{ROW_BEAT,   16'h8000, 1'b1, 1'b1, 12'd1, -28'sd32768},   // min sample
        '{ROW_BEAT,   16'h0000, 1'b1, 1'b1, 12'd2,  28'sd0},
        '{ROW_BEAT,   16'h0001, 1'b0, 1'b0, 12'd0,  28'sd0},
        '{ROW_BEAT,   16'hFFFF, 1'b1, 1'b1, 12'd3,  28'sd0},       // +1 -1 cancel
        '{ROW_BEAT,   16'h7FFF, 1'b0, 1'b0, 12'd0,  28'sd0},
        '{ROW_BEAT,   16'h7FFF, 1'b1, 1'b1, 12'd4,  28'sd65534},
        '{ROW_BEAT,   16'h8000, 1'b0, 1'b0, 12'd0,  28'sd0},
        '{ROW_BEAT,   16'h8000, 1'b1, 1'b1, 12'd5, -28'sd65536},
        '{ROW_TO_RMS, 16'h0000, 1'b0, 1'b0, 12'd0,  28'sd0},
        '{ROW_BEAT,   16'h3039, 1'b1, 1'b1, 12'd6,  28'sd0},       // one sample: no spread
        '{ROW_BEAT,   16'h7FFF, 1'b0, 1'b0, 12'd0,  28'sd0},
        '{ROW_BEAT,   16'h8000, 1'b1, 1'b0, 12'd0,  28'sd0},       // widest two-sample spread
        '{ROW_BEAT,   16'h0003, 1'b0, 1'b0, 12'd0,  28'sd0},
        '{ROW_BEAT,   16'hFFFD, 1'b1, 1'b1, 12'd8,  28'sd768},     // +3 -3: rms 3.0
        '{ROW_BEAT,   16'h0064, 1'b0, 1'b0, 12'd0,  28'sd0},
        '{ROW_BEAT,   16'h0064, 1'b1, 1'b1, 12'd9,  28'sd0},       // constant column
        '{ROW_BEAT,   16'hA5A5, 1'b0, 1'b0, 12'd0,  28'sd0},
        '{ROW_BEAT,   16'h5A5A, 1'b0, 1'b0, 12'd0,  28'sd0},
        '{ROW_BEAT,   16'h0F0F, 1'b1, 1'b0, 12'd0,  28'sd0},
        '{ROW_TO_SUM, 16'h0000, 1'b0, 1'b0, 12'd0,  28'sd0},
        '{ROW_BEAT,   16'h1234, 1'b0, 1'b0, 12'd0,  28'sd0},
        '{ROW_BEAT,   16'hEDCC, 1'b1, 1'b1, 12'd11, 28'sd0}
    };

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin
        t_col_result typed_res;
        int          rand_beats;
        int          phase;
        int          n_cols;
        int          len;
        int          pick;
        t_col_style  sty;

        rand_beats = 0;
        phase      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            case (dir_rows[k].kind)
                ROW_TO_SUM: write_mode(MODE_SUM);
                ROW_TO_RMS: write_mode(MODE_RMS);
                default: begin
                    typed_res.col   = dir_rows[k].col;
                    typed_res.power = dir_rows[k].power;
                    push_beat(dir_rows[k].sample, dir_rows[k].is_last,
                              dir_rows[k].typed, typed_res);
                end
            endcase
        end

        // Flat and swinging columns back to back: large negative and positive
        // sums, a flat RMS column and the largest RMS spread.
        steady_flow = 1'b1;
        send_column(FLAT_LEN, STY_ALL_LOW);
        send_column(FLAT_LEN, STY_ALL_HIGH);
        write_mode(MODE_RMS);
        send_column(FLAT_LEN, STY_SWING);
        send_column(FLAT_LEN, STY_ALL_LOW);
        steady_flow = 1'b0;

        // Random phases, alternating mode; some phases run without idling.
        while (rand_beats < RANDOM_BEATS) begin
            write_mode((phase % 2 == 0) ? MODE_SUM : MODE_RMS);
            steady_flow = ($urandom_range(0, 3) == 0);
            n_cols = $urandom_range(8, 30);
            repeat (n_cols) begin
                if (rand_beats < RANDOM_BEATS) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 12)      len = $urandom_range(1, 6);
                    else if (pick < 19) len = $urandom_range(7, 40);
                    else                len = $urandom_range(41, 160);
                    case ($urandom_range(0, 9))
                        6:       sty = STY_EXTREME;
                        7, 8:    sty = STY_NARROW;
                        9:       sty = STY_SWING;
                        default: sty = STY_WIDE;
                    endcase
                    send_column(len, sty);
                    rand_beats += len;
                end
            end
            phase++;
        end
        steady_flow = 1'b0;

        s_tvalid <= 1'b0;
        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d sample beats: %0d sum columns, %0d RMS columns.",
                 beats_sent, sum_cols, rms_cols);
        $display("%0d result beats checked, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && column_results_due.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // ---------------------------------------------------------------------
    // Result side: random stall after each result beat.
    // ---------------------------------------------------------------------
    always @(posedge clk) begin
        if (m_tready && m_tvalid) begin
            sink_hold = steady_flow ? 0 : $urandom_range(0, 3);
            if (sink_hold != 0) m_tready <= 1'b0;
        end else if (!m_tready) begin
            if (sink_hold <= 1) m_tready <= 1'b1;
            sink_hold = sink_hold - 1;
        end
    end

    // Compare every result beat with the oldest predicted column.
    always @(posedge clk) begin
        t_col_result got;
        t_col_result want;
        if (rst_n && m_tvalid && m_tready) begin
            got.col   = m_tdata[C_COL_W-1:0];
            got.power = m_tdata[C_OUT_W-1:C_COL_W];
            results_seen++;
            if (column_results_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, got column %0d power %0d",
                         $time, got.col, got.power);
            end else begin
                want = column_results_due.pop_front();
                if (got.col !== want.col) begin
                    mismatches++;
                    $display("%0t: column_index mismatch, expected %0d, got %0d",
                             $time, want.col, got.col);
                end
                if (got.power !== want.power) begin
                    mismatches++;
                    $display("%0t: power mismatch on column %0d, expected %0d, got %0d",
                             $time, want.col, want.power, got.power);
                end
            end
        end
    end

    // Watchdog on cycles with no beat taken on either side.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

endmodule

/* sim.f */
rtl/core/csrms_pkg.sv
rtl/core/csrms_front.sv
rtl/core/csrms_queue.sv
rtl/core/csrms_back.sv
rtl/core/column_sum_or_rms.sv
bench/testbench.sv
